[rtl/hpva_pkg.sv]
`default_nettype none
// ============================================================================
// hpva_pkg
// Shared types, codes and helper functions for the pose voting accumulator.
// ============================================================================
package hpva_pkg;

    localparam int ROT_BINS    = 12;
    localparam int DEG_PER_BIN = 30;
    localparam int PAD_R       = ROT_BINS + 2;

    localparam int BASE_BITS  = 20;
    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = 2;
    localparam int QCNT_BITS  = 3;
    localparam int CFG_BITS   = 9;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [1:0] ACT_VOTE  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_VOTE  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam logic [1:0] CFG_OCTAVE_COUNT   = 2'd0;
    localparam logic [1:0] CFG_LARGEST_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_LARGEST_HEIGHT = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  octave_a;
        logic [1:0]  octave_b;
        logic [8:0]  angle_a;
        logic [8:0]  angle_b;
        logic [8:0]  pos_ax;
        logic [7:0]  pos_ay;
        logic [8:0]  pos_bx;
        logic [7:0]  pos_by;
        logic [17:0] bin_address;
    } item_t;

    typedef struct packed {
        logic        accepted;
        logic [15:0] bin_count;
        logic [3:0]  rotation_bin;
        logic [2:0]  scale_bin;
        logic [5:0]  shift_x_bin;
        logic [4:0]  shift_y_bin;
    } result_t;

    typedef struct packed {
        logic [7:0]  str_x;
        logic [13:0] str_y;
    } stride_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [BASE_BITS-1:0] base;
        logic [3:0]           rot;
        logic [3:0]           sc;
        logic [5:0]           ix;
        logic [4:0]           iy;
        logic [17:0]          bin_address;
    } entry_t;

    function automatic logic [3:0] rot_bin(input logic [8:0] aa, input logic [8:0] ab);
        logic [10:0] v;
        logic [3:0]  r;
        v = 11'(aa) + 11'd1260 - 11'(ab);
        if (v >= 11'd1440) v = v - 11'd1440;
        if (v >= 11'd720)  v = v - 11'd720;
        if (v >= 11'd360)  v = v - 11'd360;
        r = 4'd0;
        for (int k = 1; k < ROT_BINS; k++) begin
            if (v >= 11'(k * DEG_PER_BIN)) r = r + 4'd1;
        end
        return r;
    endfunction

    function automatic logic signed [5:0] div16_trunc(input logic signed [9:0] d);
        logic [9:0] m;
        logic [5:0] q;
        m = d[9] ? 10'(-d) : 10'(d);
        q = {1'b0, m[8:4]};
        return d[9] ? $signed(6'(-q)) : $signed(q);
    endfunction

endpackage
`default_nettype wire

[rtl/hpva_front.sv]
`default_nettype none
// ============================================================================
// hpva_front
// Configuration registers, command decode and bin computation; pushes
// classified words into the queue.
// ============================================================================
module hpva_front #(
    parameter int MAX_WIDTH   = 320,
    parameter int MAX_HEIGHT  = 240,
    parameter int MAX_OCTAVES = 4
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    input  hpva_pkg::item_t                     cmd,
    input  wire                                 cfg_we,
    input  wire [hpva_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire [hpva_pkg::CFG_BITS-1:0]        cfg_data,
    input  wire [hpva_pkg::QCNT_BITS-1:0]       q_count,
    input  wire                                 init_busy,
    output logic                                busy,
    output logic                                push,
    output hpva_pkg::entry_t                    push_entry,
    output hpva_pkg::stride_t                   strides
);
    import hpva_pkg::*;

    logic [2:0]  octave_count_reg;
    logic [8:0]  largest_width_reg;
    logic [7:0]  largest_height_reg;

    logic [2:0]  oc;
    logic [8:0]  wc;
    logic [7:0]  hc;
    logic [5:0]  nx;
    logic [4:0]  ny;
    logic [7:0]  str_x_reg;
    logic [13:0] str_y_reg;

    logic        accept;
    logic [QCNT_BITS-1:0] occupancy;

    logic signed [9:0] dx;
    logic signed [9:0] dy;
    logic signed [5:0] qx;
    logic signed [5:0] qy;
    logic signed [7:0] ix_s;
    logic signed [6:0] iy_s;
    logic        oct_ok;
    logic        shift_ok;
    logic [1:0]  kind_c;
    logic [3:0]  sc_c;

    logic        s1_valid_reg;
    logic [1:0]  s1_kind_reg;
    logic [3:0]  s1_rot_reg;
    logic [3:0]  s1_sc_reg;
    logic [5:0]  s1_ix_reg;
    logic [4:0]  s1_iy_reg;
    logic [17:0] s1_addr_reg;

    logic        s2_valid_reg;
    logic [1:0]  s2_kind_reg;
    logic [3:0]  s2_rot_reg;
    logic [3:0]  s2_sc_reg;
    logic [5:0]  s2_ix_reg;
    logic [4:0]  s2_iy_reg;
    logic [17:0] s2_addr_reg;
    logic [7:0]  s2_part_reg;
    logic [13:0] s2_prod_x_reg;
    logic [18:0] s2_prod_y_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            octave_count_reg   <= 3'd4;
            largest_width_reg  <= 9'd320;
            largest_height_reg <= 8'd240;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OCTAVE_COUNT:   octave_count_reg   <= cfg_data[2:0];
                CFG_LARGEST_WIDTH:  largest_width_reg  <= cfg_data[8:0];
                CFG_LARGEST_HEIGHT: largest_height_reg <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        if (octave_count_reg == 3'd0)
            oc = 3'd1;
        else if (32'(octave_count_reg) > MAX_OCTAVES)
            oc = 3'(MAX_OCTAVES);
        else
            oc = octave_count_reg;

        if (largest_width_reg < 9'd16)
            wc = 9'd16;
        else if (32'(largest_width_reg) > MAX_WIDTH)
            wc = 9'(MAX_WIDTH);
        else
            wc = largest_width_reg;

        if (largest_height_reg < 8'd16)
            hc = 8'd16;
        else if (32'(largest_height_reg) > MAX_HEIGHT)
            hc = 8'(MAX_HEIGHT);
        else
            hc = largest_height_reg;

        nx = wc[8:3];
        ny = hc[7:3];
    end

    always_ff @(posedge clk)
    begin
        str_x_reg <= 8'(9'(oc) * 9'd28 + 9'd28);
        str_y_reg <= (14'(oc) * 14'd28 + 14'd28) * (14'(nx) + 14'd2);
    end

    assign strides.str_x = str_x_reg;
    assign strides.str_y = str_y_reg;

    assign occupancy = q_count + QCNT_BITS'(s1_valid_reg) + QCNT_BITS'(s2_valid_reg);
    assign busy      = init_busy || (occupancy >= QCNT_BITS'(QDEPTH));
    assign accept    = start && !busy;

    always_comb
    begin
        dx   = $signed({1'b0, cmd.pos_ax}) - $signed({1'b0, cmd.pos_bx});
        dy   = 10'($signed({1'b0, cmd.pos_ay}) - $signed({1'b0, cmd.pos_by}));
        qx   = div16_trunc(dx);
        qy   = div16_trunc(dy);
        ix_s = $signed({3'b000, nx[5:1]}) + 8'(qx);
        iy_s = $signed({3'b000, ny[4:1]}) + 7'(qy);
        oct_ok   = ({1'b0, cmd.octave_a} < oc) && ({1'b0, cmd.octave_b} < oc);
        shift_ok = !ix_s[7] && (ix_s[6:0] < {1'b0, nx})
                && !iy_s[6] && (iy_s[5:0] < {1'b0, ny});
        sc_c = 4'(oc) + 4'(cmd.octave_a) - 4'(cmd.octave_b);
        case (cmd.action)
            ACT_VOTE:  kind_c = (oct_ok && shift_ok) ? KIND_VOTE : KIND_NONE;
            ACT_READ:  kind_c = KIND_READ;
            ACT_CLEAR: kind_c = KIND_CLEAR;
            default:   kind_c = KIND_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg <= kind_c;
        s1_rot_reg  <= rot_bin(cmd.angle_a, cmd.angle_b);
        s1_sc_reg   <= sc_c;
        s1_ix_reg   <= ix_s[5:0];
        s1_iy_reg   <= iy_s[4:0];
        s1_addr_reg <= cmd.bin_address;

        s2_kind_reg   <= s1_kind_reg;
        s2_rot_reg    <= s1_rot_reg;
        s2_sc_reg     <= s1_sc_reg;
        s2_ix_reg     <= s1_ix_reg;
        s2_iy_reg     <= s1_iy_reg;
        s2_addr_reg   <= s1_addr_reg;
        s2_part_reg   <= 8'(s1_rot_reg) + 8'(s1_sc_reg) * 8'(PAD_R);
        s2_prod_x_reg <= 14'(s1_ix_reg) * 14'(str_x_reg);
        s2_prod_y_reg <= 19'(s1_iy_reg) * 19'(str_y_reg);
    end

    assign push = s2_valid_reg;

    always_comb
    begin
        push_entry.kind        = s2_kind_reg;
        push_entry.base        = BASE_BITS'(s2_part_reg) + BASE_BITS'(s2_prod_x_reg)
                               + BASE_BITS'(s2_prod_y_reg);
        push_entry.rot         = s2_rot_reg;
        push_entry.sc          = s2_sc_reg;
        push_entry.ix          = s2_ix_reg;
        push_entry.iy          = s2_iy_reg;
        push_entry.bin_address = s2_addr_reg;
    end

endmodule
`default_nettype wire

[rtl/hpva_queue.sv]
`default_nettype none
// ============================================================================
// hpva_queue
// Short FIFO of decoded words between the front and the back.
// ============================================================================
module hpva_queue (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             push,
    input  hpva_pkg::entry_t                push_entry,
    input  wire                             pop,
    output hpva_pkg::entry_t                head,
    output logic                            empty,
    output logic [hpva_pkg::QCNT_BITS-1:0]  count
);
    import hpva_pkg::*;

    entry_t                 slot_reg [QDEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QCNT_BITS-1:0]   count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg < QCNT_BITS'(QDEPTH))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue read while empty");

endmodule
`default_nettype wire

[rtl/hpva_back.sv]
`default_nettype none
// ============================================================================
// hpva_back
// Counter memory and sequencer: neighbourhood increments, reads, clearing
// sweeps and result words.
// ============================================================================
module hpva_back #(
    parameter int COUNT_BITS = 16,
    parameter int DEPTH      = 188160
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  hpva_pkg::entry_t    head,
    input  wire                 empty,
    input  hpva_pkg::stride_t   strides,
    output logic                pop,
    output logic                init_busy,
    output logic                done,
    output hpva_pkg::result_t   result
);
    import hpva_pkg::*;

    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int WIDE      = (ADDR_BITS > BASE_BITS) ? ADDR_BITS : BASE_BITS;

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_VOTE  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_RDOUT = 3'd4;
    localparam logic [2:0] ST_CLEAR = 3'd5;

    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [COUNT_BITS-1:0] rdata_reg;

    logic [2:0]            state_reg, state_next;
    logic [ADDR_BITS-1:0]  clr_cnt_reg, clr_cnt_next;
    logic                  wr_pend_reg, wr_pend_next;
    logic [ADDR_BITS-1:0]  wr_addr_reg, wr_addr_next;
    logic                  done_reg, done_next;
    result_t               result_reg, result_next;
    entry_t                cur_reg, cur_next;

    logic [1:0]            s_reg, s_next;
    logic [1:0]            t_reg, t_next;
    logic [1:0]            u_reg, u_next;
    logic [1:0]            v_reg, v_next;
    logic [BASE_BITS-1:0]  addr_reg, addr_next;
    logic [BASE_BITS-1:0]  row_t_reg, row_t_next;
    logic [BASE_BITS-1:0]  row_u_reg, row_u_next;
    logic [BASE_BITS-1:0]  row_v_reg, row_v_next;

    logic                  rd_en;
    logic [ADDR_BITS-1:0]  rd_idx;
    logic                  we;
    logic [ADDR_BITS-1:0]  wa;
    logic [COUNT_BITS-1:0] wd;

    logic [WIDE-1:0]       vote_wide;
    logic [WIDE-1:0]       read_wide;
    logic                  vote_in;
    logic                  read_in;
    logic                  clr_last;
    logic [COUNT_BITS+15:0] count_ext;

    assign vote_wide = WIDE'(addr_reg);
    assign read_wide = WIDE'(head.bin_address);
    assign vote_in   = vote_wide < WIDE'(DEPTH);
    assign read_in   = read_wide < WIDE'(DEPTH);
    assign clr_last  = (clr_cnt_reg == ADDR_BITS'(DEPTH - 1));
    assign count_ext = {16'd0, rdata_reg};

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        done_next    = 1'b0;
        result_next  = '0;
        cur_next     = cur_reg;
        s_next       = s_reg;
        t_next       = t_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        addr_next    = addr_reg;
        row_t_next   = row_t_reg;
        row_u_next   = row_u_reg;
        row_v_next   = row_v_reg;
        pop          = 1'b0;
        rd_en        = 1'b0;
        rd_idx       = vote_wide[ADDR_BITS-1:0];
        wr_pend_next = 1'b0;

        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                    done_next  = (state_reg == ST_CLEAR);
                end
            end
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cur_next = head;
                    case (head.kind)
                        KIND_VOTE:
                        begin
                            state_next = ST_VOTE;
                            s_next     = 2'd0;
                            t_next     = 2'd0;
                            u_next     = 2'd0;
                            v_next     = 2'd0;
                            addr_next  = head.base;
                            row_t_next = head.base;
                            row_u_next = head.base;
                            row_v_next = head.base;
                        end
                        KIND_READ:
                        begin
                            if (read_in)
                            begin
                                rd_en      = 1'b1;
                                rd_idx     = read_wide[ADDR_BITS-1:0];
                                state_next = ST_RDOUT;
                            end
                            else
                                done_next = 1'b1;
                        end
                        KIND_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        default:
                            done_next = 1'b1;
                    endcase
                end
            end
            ST_VOTE:
            begin
                rd_en        = vote_in;
                wr_pend_next = vote_in;
                if (s_reg != 2'd2)
                begin
                    s_next    = s_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
                else if (t_reg != 2'd2)
                begin
                    s_next     = 2'd0;
                    t_next     = t_reg + 1'b1;
                    row_t_next = row_t_reg + BASE_BITS'(PAD_R);
                    addr_next  = row_t_reg + BASE_BITS'(PAD_R);
                end
                else if (u_reg != 2'd2)
                begin
                    s_next     = 2'd0;
                    t_next     = 2'd0;
                    u_next     = u_reg + 1'b1;
                    row_u_next = row_u_reg + BASE_BITS'(strides.str_x);
                    row_t_next = row_u_reg + BASE_BITS'(strides.str_x);
                    addr_next  = row_u_reg + BASE_BITS'(strides.str_x);
                end
                else if (v_reg != 2'd2)
                begin
                    s_next     = 2'd0;
                    t_next     = 2'd0;
                    u_next     = 2'd0;
                    v_next     = v_reg + 1'b1;
                    row_v_next = row_v_reg + BASE_BITS'(strides.str_y);
                    row_u_next = row_v_reg + BASE_BITS'(strides.str_y);
                    row_t_next = row_v_reg + BASE_BITS'(strides.str_y);
                    addr_next  = row_v_reg + BASE_BITS'(strides.str_y);
                end
                else
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                done_next                = 1'b1;
                result_next.accepted     = 1'b1;
                result_next.rotation_bin = cur_reg.rot;
                result_next.scale_bin    = cur_reg.sc[2:0];
                result_next.shift_x_bin  = cur_reg.ix;
                result_next.shift_y_bin  = cur_reg.iy;
                state_next               = ST_IDLE;
            end
            ST_RDOUT:
            begin
                done_next             = 1'b1;
                result_next.bin_count = count_ext[15:0];
                state_next            = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign wr_addr_next = rd_idx;

    always_comb
    begin
        if (state_reg == ST_INIT || state_reg == ST_CLEAR)
        begin
            we = 1'b1;
            wa = clr_cnt_reg;
            wd = '0;
        end
        else
        begin
            we = wr_pend_reg;
            wa = wr_addr_reg;
            wd = (rdata_reg == '1) ? rdata_reg : rdata_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (rd_en)
            rdata_reg <= mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            clr_cnt_reg <= '0;
            wr_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            wr_pend_reg <= wr_pend_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= wr_addr_next;
        result_reg  <= result_next;
        cur_reg     <= cur_next;
        s_reg       <= s_next;
        t_reg       <= t_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        addr_reg    <= addr_next;
        row_t_reg   <= row_t_next;
        row_u_reg   <= row_u_next;
        row_v_reg   <= row_v_next;
    end

    assign init_busy = (state_reg == ST_INIT);
    assign done      = done_reg;
    assign result    = result_reg;

    a_drain_reports: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAIN |=> done_reg && result_reg.accepted)
        else $error("vote finished without a result word");

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> !(state_reg == ST_INIT || state_reg == ST_CLEAR))
        else $error("increment write during clearing sweep");

    a_quiet_init: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INIT |-> !done_reg && !pop)
        else $error("activity during initial clearing");

endmodule
`default_nettype wire

[rtl/hough_pose_vote_accumulator_top.sv]
`default_nettype none
// ============================================================================
// hough_pose_vote_accumulator_top
// Pose voting accumulator for a generalized Hough transform.
// ============================================================================
// A command is taken when start is high and busy is low; each command gives
// exactly one result word, shown for a single cycle with done high, and the
// receiver must take it then. A vote updates the 81 cells of its 3x3x3x3
// neighbourhood through a read-modify-write pipeline on the counter memory,
// one cell a cycle: the back end takes the word from the queue, performs the
// 81 increments and then finishes with the result word. A read takes the
// word, reads its counter and then reports it; a read outside the memory, a
// rejected vote or a no-op reports as soon as the back end takes the word.
// A clear sweeps the whole memory one entry a cycle (DEPTH entries, 188160 at
// the default sizes) and then reports. After reset the same sweep runs once
// with busy high and no result. Up to four commands wait between the front
// stages and the queue, so start is accepted while an earlier vote is still
// running. Configuration must be written only while no command is
// outstanding; the block itself does not enforce it.
// ============================================================================
module hough_pose_vote_accumulator_top #(
    parameter int MAX_WIDTH   = 320,
    parameter int MAX_HEIGHT  = 240,
    parameter int MAX_OCTAVES = 4,
    parameter int COUNT_BITS  = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  hpva_pkg::item_t                     cmd,
    output logic                                done,
    output hpva_pkg::result_t                   result,
    input  wire                                 cfg_we,
    input  wire [hpva_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire [hpva_pkg::CFG_BITS-1:0]        cfg_data
);
    import hpva_pkg::*;

    localparam int DEPTH = PAD_R * (2 * MAX_OCTAVES + 2) * (MAX_WIDTH / 8 + 2)
                         * (MAX_HEIGHT / 8 + 2);

    logic                   push;
    entry_t                 push_entry;
    stride_t                strides;
    logic                   pop;
    entry_t                 head;
    logic                   empty;
    logic [QCNT_BITS-1:0]   q_count;
    logic                   init_busy;

    hpva_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_OCTAVES (MAX_OCTAVES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_count    (q_count),
        .init_busy  (init_busy),
        .busy       (busy),
        .push       (push),
        .push_entry (push_entry),
        .strides    (strides)
    );

    hpva_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .count      (q_count)
    );

    hpva_back #(
        .COUNT_BITS (COUNT_BITS),
        .DEPTH      (DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .strides    (strides),
        .pop        (pop),
        .init_busy  (init_busy),
        .done       (done),
        .result     (result)
    );

endmodule
`default_nettype wire
